[rtl/motor_winding_thermal_estimator_macros.svh]
// assertion macros for the motor winding thermal estimator
// used by the top level only, no other dependencies
`ifndef MOTOR_WINDING_THERMAL_ESTIMATOR_MACROS_SVH
`define MOTOR_WINDING_THERMAL_ESTIMATOR_MACROS_SVH

// same-cycle implication under reset
`define MWTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define MWTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mwte_pkg.sv]
// types and constants of the motor winding thermal estimator
// no dependencies
`timescale 1ns / 1ps

package mwte_pkg;

    localparam logic [31:0] T_COOL   = 32'd19539558;
    localparam logic [63:0] T_SPAN   = 64'd6881280;
    localparam logic [63:0] RCP_105  = 64'd343131400180610;
    localparam logic [63:0] HEAT_CAP = 64'h4000_0000_0000_0000;
    localparam logic [31:0] CUR_MAX  = 32'hFFFF_FFFF;
    localparam logic [32:0] Q_ONE    = 33'd65536;
    localparam logic [6:0]  MUL_DONE = 7'd4;
    localparam logic [6:0]  DIV_DONE = 7'd64;

    localparam logic REQ_STEP   = 1'b0;
    localparam logic REQ_RELOAD = 1'b1;

    localparam logic [3:0] REG_STEP_OVER_CAP = 4'd0;
    localparam logic [3:0] REG_THERMAL_RES   = 4'd1;
    localparam logic [3:0] REG_NOMINAL_RES   = 4'd2;
    localparam logic [3:0] REG_RES_TEMPCO    = 4'd3;
    localparam logic [3:0] REG_KT_COOL       = 4'd4;
    localparam logic [3:0] REG_KT_HOT        = 4'd5;
    localparam logic [3:0] REG_GEAR          = 4'd6;
    localparam logic [3:0] REG_AMBIENT       = 4'd7;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         motor_index;
        logic signed [31:0] load_force;
    } req_t;

    typedef struct packed {
        logic [3:0]  motor_echo;
        logic [31:0] winding_temperature;
        logic        saturated_flag;
        logic        bad_kt_flag;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DELTA_MUL,
        ST_DELTA_RCP,
        ST_DEN_MUL,
        ST_CUR_DIV,
        ST_SQR_MUL,
        ST_TCR_MUL,
        ST_RES_MUL,
        ST_PIN_MUL,
        ST_POUT_DIV,
        ST_CHG_MUL,
        ST_FINISH
    } state_t;

endpackage

[rtl/motor_winding_thermal_estimator.sv]
// motor winding thermal estimator: fsm, shared 32x32 multiplier and radix-2 divider
// depends on mwte_pkg and motor_winding_thermal_estimator_macros.svh
// step word: one pass through the fsm from acceptance to result, next word can be taken in the cycle the result leaves
// the pass runs at most two divisions and eight multiplications, and waits in finish for the output
// reload word or motor index out of range: result valid in the cycle after acceptance
// reset: async active low, control and configuration registers to defaults, every motor reads 298.15 K
`timescale 1ns / 1ps

`include "motor_winding_thermal_estimator_macros.svh"

module motor_winding_thermal_estimator #(
    parameter int MOTORS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mwte_pkg::req_t    req_word,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output mwte_pkg::rsp_t    rsp_word,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    mwte_pkg::state_t state_reg, state_next;
    logic [6:0]   cnt_reg;

    logic [31:0]  soc_reg, rth_reg, rnom_reg, tcr_reg, ktc_reg, kth_reg, gear_reg;
    logic [26:0]  amb_reg;
    logic [31:0]  base_reg;
    logic [MOTORS-1:0] vld_reg;
    logic [31:0]  mem [MOTORS];
    logic [31:0]  rd_reg;
    logic         hit_reg;

    logic         rsp_valid_reg;
    mwte_pkg::rsp_t rsp_reg;

    logic [3:0]   idx_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0]  fmag_reg;
    logic [31:0]  t_reg, ad_reg, emag_reg;
    logic         tneg_reg, eneg_reg, kneg_reg, fneg_reg, bad_reg;
    logic [47:0]  i2_reg;
    logic [62:0]  pmag_reg;
    logic [31:0]  newt_reg;
    logic         sat_reg;

    logic [63:0]  mul_a_reg, mul_b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  dvd_reg, dvs_reg;
    logic [64:0]  rem_reg;

    logic         accept, out_free, in_range, is_mul, is_div, mul_done, div_done;
    logic [31:0]  t_sel;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  rem_sh;
    logic         q_bit;
    logic signed [65:0] kt_s;
    logic         kt_bad;
    logic [63:0]  den;
    logic         den_zero;
    logic [31:0]  cur_zero, cur_div;
    logic [31:0]  m_val;
    logic [32:0]  fm;
    logic signed [64:0] pin_s, net_s;
    logic [64:0]  nmag;
    logic [63:0]  chg;
    logic [63:0]  sum;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwte_pkg::ST_IDLE:
            begin
                if (accept && req_word.req_type == mwte_pkg::REQ_STEP && in_range)
                    state_next = mwte_pkg::ST_READ;
            end
            mwte_pkg::ST_READ:      state_next = mwte_pkg::ST_LOAD;
            mwte_pkg::ST_LOAD:      state_next = mwte_pkg::ST_DELTA_MUL;
            mwte_pkg::ST_DELTA_MUL: if (mul_done) state_next = mwte_pkg::ST_DELTA_RCP;
            mwte_pkg::ST_DELTA_RCP:
            begin
                if (mul_done)
                    state_next = kt_bad ? mwte_pkg::ST_POUT_DIV : mwte_pkg::ST_DEN_MUL;
            end
            mwte_pkg::ST_DEN_MUL:
            begin
                if (mul_done)
                    state_next = den_zero ? mwte_pkg::ST_SQR_MUL : mwte_pkg::ST_CUR_DIV;
            end
            mwte_pkg::ST_CUR_DIV:   if (div_done) state_next = mwte_pkg::ST_SQR_MUL;
            mwte_pkg::ST_SQR_MUL:   if (mul_done) state_next = mwte_pkg::ST_TCR_MUL;
            mwte_pkg::ST_TCR_MUL:   if (mul_done) state_next = mwte_pkg::ST_RES_MUL;
            mwte_pkg::ST_RES_MUL:   if (mul_done) state_next = mwte_pkg::ST_PIN_MUL;
            mwte_pkg::ST_PIN_MUL:   if (mul_done) state_next = mwte_pkg::ST_POUT_DIV;
            mwte_pkg::ST_POUT_DIV:  if (div_done) state_next = mwte_pkg::ST_CHG_MUL;
            mwte_pkg::ST_CHG_MUL:   if (mul_done) state_next = mwte_pkg::ST_FINISH;
            mwte_pkg::ST_FINISH:    if (out_free) state_next = mwte_pkg::ST_IDLE;
            default:                state_next = mwte_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        out_free  = !rsp_valid_reg || rsp_ready;
        req_ready = (state_reg == mwte_pkg::ST_IDLE) && out_free;
        accept    = req_valid && req_ready;
        cfg_ready = 1'b1;
        is_mul    = state_reg inside {mwte_pkg::ST_DELTA_MUL, mwte_pkg::ST_DELTA_RCP,
                                      mwte_pkg::ST_DEN_MUL, mwte_pkg::ST_SQR_MUL,
                                      mwte_pkg::ST_TCR_MUL, mwte_pkg::ST_RES_MUL,
                                      mwte_pkg::ST_PIN_MUL, mwte_pkg::ST_CHG_MUL};
        is_div    = state_reg inside {mwte_pkg::ST_CUR_DIV, mwte_pkg::ST_POUT_DIV};
        mul_done  = is_mul && (cnt_reg == mwte_pkg::MUL_DONE);
        div_done  = is_div && (cnt_reg == mwte_pkg::DIV_DONE);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;
    assign in_range  = 32'(req_word.motor_index) < 32'(MOTORS);
    assign t_sel     = hit_reg ? rd_reg : base_reg;

    // shared multiplier, one 32x32 partial product per cycle
    always_comb
    begin
        pa = cnt_reg[0] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        pb = cnt_reg[1] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // shared restoring divider, one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg[63:0], dvd_reg[63]};
        q_bit  = rem_sh >= {1'b0, dvs_reg};
    end

    // stage results
    always_comb
    begin
        kt_s = $signed({34'd0, ktc_reg}) +
               (kneg_reg ? -$signed({2'd0, acc_reg[118:55]})
                         : $signed({2'd0, acc_reg[118:55]}));
        kt_bad = kt_s[65] || (kt_s == 66'sd0);
        den = (acc_reg[127:80] != 48'd0) ? {64{1'b1}} : acc_reg[79:16];
        den_zero = den == 64'd0;
        cur_zero = (fmag_reg != 32'd0) ? mwte_pkg::CUR_MAX : 32'd0;
        cur_div  = (dvd_reg[63:32] != 32'd0) ? mwte_pkg::CUR_MAX : dvd_reg[31:0];
        m_val = acc_reg[63:32];
        if (tneg_reg)
            fm = ({1'b0, m_val} >= mwte_pkg::Q_ONE) ? ({1'b0, m_val} - mwte_pkg::Q_ONE)
                                                    : (mwte_pkg::Q_ONE - {1'b0, m_val});
        else
            fm = {1'b0, m_val} + mwte_pkg::Q_ONE;
        pin_s = fneg_reg ? -$signed({2'd0, pmag_reg}) : $signed({2'd0, pmag_reg});
        net_s = pin_s - (eneg_reg ? -$signed({17'd0, dvd_reg[47:0]})
                                  : $signed({17'd0, dvd_reg[47:0]}));
        nmag  = net_s[64] ? 65'(-net_s) : 65'(net_s);
        chg   = (acc_reg[127:32] > 96'(mwte_pkg::HEAT_CAP)) ? mwte_pkg::HEAT_CAP
                                                             : acc_reg[95:32];
        sum   = {32'd0, t_reg} + chg;
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwte_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
            base_reg      <= mwte_pkg::T_COOL;
            soc_reg       <= 32'd1;
            rth_reg       <= 32'd65536;
            rnom_reg      <= 32'd65536;
            tcr_reg       <= 32'd0;
            ktc_reg       <= 32'd65536;
            kth_reg       <= 32'd65536;
            gear_reg      <= 32'd65536;
            amb_reg       <= 27'(mwte_pkg::T_COOL);
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else if (is_mul || is_div)
                cnt_reg <= cnt_reg + 7'd1;

            if (accept && (req_word.req_type == mwte_pkg::REQ_RELOAD || !in_range))
                rsp_valid_reg <= 1'b1;
            else if (state_reg == mwte_pkg::ST_FINISH && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            if (accept && req_word.req_type == mwte_pkg::REQ_RELOAD)
            begin
                vld_reg  <= '0;
                base_reg <= {5'd0, amb_reg};
            end
            else if (state_reg == mwte_pkg::ST_FINISH && out_free)
                vld_reg[addr_reg] <= 1'b1;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mwte_pkg::REG_STEP_OVER_CAP: soc_reg  <= cfg_data;
                    mwte_pkg::REG_THERMAL_RES:   rth_reg  <= cfg_data;
                    mwte_pkg::REG_NOMINAL_RES:   rnom_reg <= cfg_data;
                    mwte_pkg::REG_RES_TEMPCO:    tcr_reg  <= cfg_data;
                    mwte_pkg::REG_KT_COOL:       ktc_reg  <= cfg_data;
                    mwte_pkg::REG_KT_HOT:        kth_reg  <= cfg_data;
                    mwte_pkg::REG_GEAR:          gear_reg <= cfg_data;
                    mwte_pkg::REG_AMBIENT:       amb_reg  <= cfg_data[26:0];
                    default: ;
                endcase
            end
        end
    end

    // temperature store
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[addr_reg];
        if (state_reg == mwte_pkg::ST_FINISH && out_free)
            mem[addr_reg] <= newt_reg;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mwte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_reg  <= req_word.motor_index;
                    addr_reg <= AW'(req_word.motor_index);
                    fmag_reg <= req_word.load_force[31] ? (32'd0 - req_word.load_force)
                                                        : req_word.load_force;
                    bad_reg  <= 1'b0;
                    if (req_word.req_type == mwte_pkg::REQ_RELOAD)
                        rsp_reg <= '{motor_echo: 4'd0, winding_temperature: {5'd0, amb_reg},
                                     saturated_flag: 1'b0, bad_kt_flag: 1'b0};
                    else if (!in_range)
                        rsp_reg <= '{motor_echo: req_word.motor_index,
                                     winding_temperature: 32'd0,
                                     saturated_flag: 1'b0, bad_kt_flag: 1'b0};
                end
            end
            mwte_pkg::ST_READ:
            begin
                hit_reg <= vld_reg[addr_reg];
            end
            mwte_pkg::ST_LOAD:
            begin
                t_reg    <= t_sel;
                tneg_reg <= t_sel < mwte_pkg::T_COOL;
                ad_reg   <= (t_sel < mwte_pkg::T_COOL) ? (mwte_pkg::T_COOL - t_sel)
                                                       : (t_sel - mwte_pkg::T_COOL);
                eneg_reg <= t_sel < {5'd0, amb_reg};
                emag_reg <= (t_sel < {5'd0, amb_reg}) ? ({5'd0, amb_reg} - t_sel)
                                                      : (t_sel - {5'd0, amb_reg});
                kneg_reg <= (kth_reg < ktc_reg) != (t_sel < mwte_pkg::T_COOL);
                mul_a_reg <= {32'd0, (kth_reg < ktc_reg) ? (ktc_reg - kth_reg)
                                                         : (kth_reg - ktc_reg)};
                mul_b_reg <= {32'd0, (t_sel < mwte_pkg::T_COOL) ? (mwte_pkg::T_COOL - t_sel)
                                                                : (t_sel - mwte_pkg::T_COOL)};
                acc_reg   <= '0;
            end
            mwte_pkg::ST_DELTA_MUL, mwte_pkg::ST_DELTA_RCP, mwte_pkg::ST_DEN_MUL,
            mwte_pkg::ST_SQR_MUL, mwte_pkg::ST_TCR_MUL, mwte_pkg::ST_RES_MUL,
            mwte_pkg::ST_PIN_MUL, mwte_pkg::ST_CHG_MUL:
            begin
                if (!mul_done)
                    acc_reg <= acc_reg + pp_sh;
                else
                begin
                    acc_reg <= '0;
                    rem_reg <= '0;
                    case (state_reg)
                        mwte_pkg::ST_DELTA_MUL:
                        begin
                            // divide by 105 K as 2^16 then a reciprocal of 105
                            mul_a_reg <= {16'd0, acc_reg[63:16]};
                            mul_b_reg <= mwte_pkg::RCP_105;
                        end
                        mwte_pkg::ST_DELTA_RCP:
                        begin
                            if (kt_bad)
                            begin
                                bad_reg  <= 1'b1;
                                pmag_reg <= '0;
                                fneg_reg <= 1'b0;
                                dvd_reg  <= {16'd0, emag_reg, 16'd0};
                                dvs_reg  <= (rth_reg == 32'd0) ? 64'd1 : {32'd0, rth_reg};
                            end
                            else
                            begin
                                mul_a_reg <= kt_s[63:0];
                                mul_b_reg <= {32'd0, gear_reg};
                            end
                        end
                        mwte_pkg::ST_DEN_MUL:
                        begin
                            if (den_zero)
                            begin
                                mul_a_reg <= {32'd0, cur_zero};
                                mul_b_reg <= {32'd0, cur_zero};
                            end
                            dvd_reg <= {16'd0, fmag_reg, 16'd0};
                            dvs_reg <= den;
                        end
                        mwte_pkg::ST_SQR_MUL:
                        begin
                            i2_reg    <= acc_reg[63:16];
                            mul_a_reg <= {32'd0, tcr_reg};
                            mul_b_reg <= {32'd0, ad_reg};
                        end
                        mwte_pkg::ST_TCR_MUL:
                        begin
                            fneg_reg  <= tneg_reg && ({1'b0, m_val} > mwte_pkg::Q_ONE);
                            mul_a_reg <= {32'd0, rnom_reg};
                            mul_b_reg <= {31'd0, fm};
                        end
                        mwte_pkg::ST_RES_MUL:
                        begin
                            mul_a_reg <= {16'd0, i2_reg};
                            mul_b_reg <= acc_reg[79:16];
                        end
                        mwte_pkg::ST_PIN_MUL:
                        begin
                            pmag_reg <= (acc_reg[127:16] > 112'(mwte_pkg::HEAT_CAP))
                                        ? mwte_pkg::HEAT_CAP[62:0] : acc_reg[78:16];
                            dvd_reg  <= {16'd0, emag_reg, 16'd0};
                            dvs_reg  <= (rth_reg == 32'd0) ? 64'd1 : {32'd0, rth_reg};
                        end
                        default:
                        begin
                            if (net_s[64])
                            begin
                                sat_reg  <= chg > {32'd0, t_reg};
                                newt_reg <= (chg > {32'd0, t_reg}) ? 32'd0
                                                                   : t_reg - chg[31:0];
                            end
                            else
                            begin
                                sat_reg  <= sum[63:32] != 32'd0;
                                newt_reg <= (sum[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                  : sum[31:0];
                            end
                        end
                    endcase
                end
            end
            mwte_pkg::ST_CUR_DIV, mwte_pkg::ST_POUT_DIV:
            begin
                if (!div_done)
                begin
                    rem_reg <= q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                    dvd_reg <= {dvd_reg[62:0], q_bit};
                end
                else
                begin
                    acc_reg <= '0;
                    rem_reg <= '0;
                    case (state_reg)
                        mwte_pkg::ST_CUR_DIV:
                        begin
                            mul_a_reg <= {32'd0, cur_div};
                            mul_b_reg <= {32'd0, cur_div};
                        end
                        default:
                        begin
                            mul_a_reg <= nmag[63:0];
                            mul_b_reg <= {32'd0, soc_reg};
                        end
                    endcase
                end
            end
            mwte_pkg::ST_FINISH:
            begin
                if (out_free)
                    rsp_reg <= '{motor_echo: idx_reg, winding_temperature: newt_reg,
                                 saturated_flag: sat_reg, bad_kt_flag: bad_reg};
            end
            default: ;
        endcase
    end

    `MWTE_ASSERT_NEXT(a_step_starts_read,
        accept && req_word.req_type == mwte_pkg::REQ_STEP && in_range,
        state_reg == mwte_pkg::ST_READ, "in-range step did not start a read")
    `MWTE_ASSERT_NEXT(a_finish_gives_word,
        state_reg == mwte_pkg::ST_FINISH && out_free,
        rsp_valid_reg && rsp_reg.motor_echo == $past(idx_reg), "finished step lost its word")
    `MWTE_ASSERT_NOW(a_mul_count_bound, is_mul, cnt_reg <= mwte_pkg::MUL_DONE,
        "multiplier pass count overran")
    `MWTE_ASSERT_NOW(a_busy_not_ready, state_reg != mwte_pkg::ST_IDLE && req_valid,
        !accept, "word accepted while busy")

endmodule

[dv/tb_motor_winding_thermal_estimator.sv]
// testbench for motor_winding_thermal_estimator: directed and random step and reload words
// checked against an in-bench fixed point thermal predictor; depends on mwte_pkg and motor_winding_thermal_estimator
`timescale 1ns / 1ps

module tb_motor_winding_thermal_estimator;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    mwte_pkg::req_t req_word = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    mwte_pkg::rsp_t rsp_word;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [3:0]     cfg_index = '0;
    logic [31:0]    cfg_data = '0;

    logic [31:0]    reg_shadow [8];
    logic [31:0]    temp_shadow [16];
    mwte_pkg::rsp_t expected_words [$];
    int             mismatches = 0;
    int             burst_left = 0;
    int             stall_left = 0;
    int             stall_mode = 0;

    motor_winding_thermal_estimator #(.MOTORS(16)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] mul_shift_clamp(input logic [63:0] a, input logic [63:0] b,
                                                    input int sh, input logic [63:0] cap);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        if (p > {64'd0, cap})
        begin
            return cap;
        end
        return p[63:0];
    endfunction

    function automatic mwte_pkg::rsp_t predict_winding(input mwte_pkg::req_t w);
        mwte_pkg::rsp_t r;
        logic [31:0] fraw;
        logic [63:0] fmag, t, ad, dmag, delta, den, cur, i2, m, fm, rmag, pmag;
        logic [63:0] emag, pout_mag, rth, nmag, chg, newt;
        logic        tneg, dneg, eneg;
        longint      kt, pin, pout, net, factor;
        r = '0;
        if (w.req_type == mwte_pkg::REQ_RELOAD)
        begin
            for (int i = 0; i < 16; i++)
            begin
                temp_shadow[i] = reg_shadow[mwte_pkg::REG_AMBIENT];
            end
            r.winding_temperature = reg_shadow[mwte_pkg::REG_AMBIENT];
            return r;
        end
        fraw = w.load_force;
        fmag = fraw[31] ? (64'h1_0000_0000 - {32'd0, fraw}) : {32'd0, fraw};
        t = {32'd0, temp_shadow[w.motor_index]};
        tneg = t < mwte_pkg::T_COOL;
        ad = tneg ? (mwte_pkg::T_COOL - t) : (t - mwte_pkg::T_COOL);
        dneg = reg_shadow[mwte_pkg::REG_KT_HOT] < reg_shadow[mwte_pkg::REG_KT_COOL];
        dmag = dneg ? (reg_shadow[mwte_pkg::REG_KT_COOL] - reg_shadow[mwte_pkg::REG_KT_HOT])
                    : (reg_shadow[mwte_pkg::REG_KT_HOT] - reg_shadow[mwte_pkg::REG_KT_COOL]);
        delta = (dmag * ad) / mwte_pkg::T_SPAN;
        kt = longint'({32'd0, reg_shadow[mwte_pkg::REG_KT_COOL]})
             + ((dneg != tneg) ? -longint'(delta) : longint'(delta));
        pin = 0;
        if (kt <= 0)
        begin
            r.bad_kt_flag = 1'b1;
        end
        else
        begin
            den = mul_shift_clamp(kt, reg_shadow[mwte_pkg::REG_GEAR], 16, '1);
            if (den == 0)
            begin
                cur = (fmag != 0) ? {32'd0, mwte_pkg::CUR_MAX} : 64'd0;
            end
            else
            begin
                cur = (fmag << 16) / den;
                if (cur > mwte_pkg::CUR_MAX)
                begin
                    cur = mwte_pkg::CUR_MAX;
                end
            end
            i2 = (cur * cur) >> 16;
            m = mul_shift_clamp(reg_shadow[mwte_pkg::REG_RES_TEMPCO], ad, 32, '1);
            factor = 65536 + (tneg ? -longint'(m) : longint'(m));
            fm = (factor < 0) ? -factor : factor;
            rmag = mul_shift_clamp(reg_shadow[mwte_pkg::REG_NOMINAL_RES], fm, 16, '1);
            pmag = mul_shift_clamp(i2, rmag, 16, mwte_pkg::HEAT_CAP);
            pin = (factor < 0) ? -longint'(pmag) : longint'(pmag);
        end
        eneg = t < reg_shadow[mwte_pkg::REG_AMBIENT];
        emag = eneg ? (reg_shadow[mwte_pkg::REG_AMBIENT] - t)
                    : (t - reg_shadow[mwte_pkg::REG_AMBIENT]);
        rth = (reg_shadow[mwte_pkg::REG_THERMAL_RES] == 0) ? 64'd1
                                                          : reg_shadow[mwte_pkg::REG_THERMAL_RES];
        pout_mag = (emag << 16) / rth;
        pout = eneg ? -longint'(pout_mag) : longint'(pout_mag);
        net = pin - pout;
        nmag = (net < 0) ? -net : net;
        chg = mul_shift_clamp(nmag, reg_shadow[mwte_pkg::REG_STEP_OVER_CAP], 32,
                              mwte_pkg::HEAT_CAP);
        if (net < 0)
        begin
            if (chg > t)
            begin
                newt = 0;
                r.saturated_flag = 1'b1;
            end
            else
            begin
                newt = t - chg;
            end
        end
        else
        begin
            newt = t + chg;
            if (newt > 64'hFFFF_FFFF)
            begin
                newt = 64'hFFFF_FFFF;
                r.saturated_flag = 1'b1;
            end
        end
        temp_shadow[w.motor_index] = newt[31:0];
        r.motor_echo = w.motor_index;
        r.winding_temperature = newt[31:0];
        return r;
    endfunction

    task automatic send_word(input logic kind, input logic [3:0] motor, input logic [31:0] force_q);
        mwte_pkg::req_t w;
        int   gap;
        w.req_type = kind;
        w.motor_index = motor;
        w.load_force = force_q;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        do @(negedge clk); while (!req_ready);
        @(posedge clk);
        expected_words.insert(expected_words.size(), predict_winding(w));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        if (idx <= mwte_pkg::REG_AMBIENT)
        begin
            reg_shadow[idx] = (idx == mwte_pkg::REG_AMBIENT) ? (value & 32'h07FF_FFFF) : value;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_force();
        logic [31:0] f;
        f = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -f : f;
    endfunction

    function automatic logic [31:0] random_reg_value();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return 32'd1;
            default: return $urandom >> $urandom_range(0, 24);
        endcase
    endfunction

    task automatic test_defaults();
        send_word(mwte_pkg::REQ_STEP, 4'd0, 32'd0);
        send_word(mwte_pkg::REQ_STEP, 4'd15, 32'h7FFF_FFFF);
        send_word(mwte_pkg::REQ_STEP, 4'd15, 32'h8000_0000);
        send_word(mwte_pkg::REQ_STEP, 4'd7, 32'hFFFF_FFFF);
        send_word(mwte_pkg::REQ_RELOAD, 4'd15, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_heating();
        write_reg(mwte_pkg::REG_STEP_OVER_CAP, 32'h0100_0000);
        write_reg(mwte_pkg::REG_THERMAL_RES, 32'd10 << 16);
        write_reg(mwte_pkg::REG_NOMINAL_RES, 32'd2 << 16);
        write_reg(mwte_pkg::REG_RES_TEMPCO, 32'h0100_0000);
        write_reg(mwte_pkg::REG_KT_COOL, 32'h0000_8000);
        write_reg(mwte_pkg::REG_KT_HOT, 32'h0000_6000);
        write_reg(mwte_pkg::REG_GEAR, 32'd4 << 16);
        for (int i = 0; i < 6; i++)
        begin
            send_word(mwte_pkg::REQ_STEP, 4'd3, 32'd200 << 16);
        end
        send_word(mwte_pkg::REQ_STEP, 4'd3, 32'd0);
        wait_drained();
    endtask

    task automatic test_saturation();
        write_reg(mwte_pkg::REG_STEP_OVER_CAP, 32'hFFFF_FFFF);
        write_reg(mwte_pkg::REG_NOMINAL_RES, 32'hFFFF_FFFF);
        write_reg(mwte_pkg::REG_KT_COOL, 32'd1);
        write_reg(mwte_pkg::REG_KT_HOT, 32'd1);
        write_reg(mwte_pkg::REG_GEAR, 32'h0001_0000);
        send_word(mwte_pkg::REQ_STEP, 4'd5, 32'h7FFF_FFFF);
        send_word(mwte_pkg::REQ_STEP, 4'd5, 32'h8000_0000);
        wait_drained();
        write_reg(mwte_pkg::REG_AMBIENT, 32'd17901158);
        write_reg(mwte_pkg::REG_THERMAL_RES, 32'd0);
        send_word(mwte_pkg::REQ_STEP, 4'd5, 32'd0);
        wait_drained();
    endtask

    task automatic test_bad_kt_and_negative_resistance();
        write_reg(mwte_pkg::REG_KT_COOL, 32'd1);
        write_reg(mwte_pkg::REG_KT_HOT, 32'hFFFF_FFFF);
        write_reg(mwte_pkg::REG_AMBIENT, 32'd17901158);
        write_reg(mwte_pkg::REG_THERMAL_RES, 32'h0001_0000);
        write_reg(mwte_pkg::REG_STEP_OVER_CAP, 32'h0010_0000);
        send_word(mwte_pkg::REQ_RELOAD, 4'd0, 32'd0);
        send_word(mwte_pkg::REQ_STEP, 4'd9, 32'd1000 << 16);
        wait_drained();
        write_reg(mwte_pkg::REG_KT_COOL, 32'h0001_0000);
        write_reg(mwte_pkg::REG_KT_HOT, 32'h0001_0000);
        write_reg(mwte_pkg::REG_RES_TEMPCO, 32'hFFFF_FFFF);
        write_reg(mwte_pkg::REG_NOMINAL_RES, 32'h0001_0000);
        send_word(mwte_pkg::REQ_STEP, 4'd9, 32'd300 << 16);
        send_word(mwte_pkg::REQ_STEP, 4'd10, -(32'd300 << 16));
        wait_drained();
    endtask

    task automatic test_zero_divisor();
        write_reg(mwte_pkg::REG_RES_TEMPCO, 32'd0);
        write_reg(mwte_pkg::REG_GEAR, 32'd1);
        write_reg(mwte_pkg::REG_KT_COOL, 32'd1);
        write_reg(mwte_pkg::REG_KT_HOT, 32'd1);
        send_word(mwte_pkg::REQ_RELOAD, 4'd0, 32'd0);
        send_word(mwte_pkg::REQ_STEP, 4'd1, 32'd0);
        send_word(mwte_pkg::REQ_STEP, 4'd2, 32'd1);
        wait_drained();
    endtask

    task automatic test_unused_registers();
        for (int i = 1; i <= 8; i++)
        begin
            write_reg(4'(mwte_pkg::REG_AMBIENT + i), $urandom);
        end
        send_word(mwte_pkg::REQ_STEP, 4'd4, 32'd50 << 16);
        send_word(mwte_pkg::REQ_RELOAD, 4'd0, 32'd0);
        wait_drained();
    endtask

    task automatic test_random();
        logic [31:0] amb;
        for (int p = 0; p < 10; p++)
        begin
            for (int r = 0; r < 7; r++)
            begin
                write_reg(4'(r), random_reg_value());
            end
            case ($urandom_range(0, 4))
                0: amb = 32'd17901158;
                1: amb = 32'd131072000;
                2: amb = $urandom & 32'h07FF_FFFF;
                default: amb = $urandom_range(17901158, 131072000);
            endcase
            write_reg(mwte_pkg::REG_AMBIENT, amb);
            send_word(mwte_pkg::REQ_RELOAD, 4'($urandom), random_force());
            for (int i = 0; i < 41; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_word(mwte_pkg::REQ_RELOAD, 4'($urandom), $urandom);
                end
                else
                begin
                    send_word(mwte_pkg::REQ_STEP, 4'($urandom_range(0, 15)), random_force());
                end
            end
            wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    $display("%t unexpected word: expected none, actual %h", $realtime, rsp_word);
                end
                else
                begin
                    mwte_pkg::rsp_t e;
                    e = expected_words.pop_front();
                    if (e.motor_echo !== rsp_word.motor_echo)
                    begin
                        mismatches++;
                        $display("%t motor_echo: expected %h, actual %h",
                                 $realtime, e.motor_echo, rsp_word.motor_echo);
                    end
                    if (e.winding_temperature !== rsp_word.winding_temperature)
                    begin
                        mismatches++;
                        $display("%t winding_temperature: expected %h, actual %h",
                                 $realtime, e.winding_temperature, rsp_word.winding_temperature);
                    end
                    if (e.saturated_flag !== rsp_word.saturated_flag)
                    begin
                        mismatches++;
                        $display("%t saturated_flag: expected %b, actual %b",
                                 $realtime, e.saturated_flag, rsp_word.saturated_flag);
                    end
                    if (e.bad_kt_flag !== rsp_word.bad_kt_flag)
                    begin
                        mismatches++;
                        $display("%t bad_kt_flag: expected %b, actual %b",
                                 $realtime, e.bad_kt_flag, rsp_word.bad_kt_flag);
                    end
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial
    begin
        reg_shadow = '{32'd1, 32'd65536, 32'd65536, 32'd0, 32'd65536, 32'd65536, 32'd65536,
                       mwte_pkg::T_COOL};
        for (int i = 0; i < 16; i++)
        begin
            temp_shadow[i] = mwte_pkg::T_COOL;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_heating();
        test_saturation();
        test_bad_kt_and_negative_resistance();
        test_zero_divisor();
        test_unused_registers();
        test_random();
        wait_drained();
        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/mwte_pkg.sv
rtl/motor_winding_thermal_estimator.sv
dv/tb_motor_winding_thermal_estimator.sv
